>>> design/skcim_pkg.sv
// Shared types, codes and defaults for the skewed cache index map.
`default_nettype none

package skcim_pkg;

    localparam int MAX_LOG_SETS_DEF = 15;
    localparam int NUM_WAYS         = 4;
    localparam int WAY_W            = $clog2(NUM_WAYS);

    localparam int MODE_W  = 2;
    localparam int LS_W    = 4;
    localparam int WC_W    = 3;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MAP_UNSHUF = 2'd0,
        MAP_HG     = 2'd1,
        MAP_ROT    = 2'd2,
        MAP_OFF    = 2'd3
    } t_map_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_SETS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAY_COUNT = 2'd2;

    localparam t_map_mode        RST_MAP_MODE  = MAP_HG;
    localparam logic [LS_W-1:0]  RST_LOG_SETS  = 4'd10;
    localparam logic [WC_W-1:0]  RST_WAY_COUNT = 3'd4;

    typedef struct packed {
        t_map_mode        map_mode;
        logic [LS_W-1:0]  log_sets;
        logic [WC_W-1:0]  way_count;
    } t_cfg;

endpackage

`default_nettype wire

>>> design/skcim_addr_if.sv
// Address channel: valid/ready handshake carrying one block address.
`default_nettype none

interface skcim_addr_if #(
    parameter int ADDR_W = 2 * skcim_pkg::MAX_LOG_SETS_DEF
) ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] block_addr;

    modport source (output valid, output block_addr, input ready);
    modport sink   (input valid, input block_addr, output ready);
endinterface

`default_nettype wire

>>> design/skcim_line_if.sv
// Line index channel: valid/ready handshake carrying four bank line indexes.
`default_nettype none

interface skcim_line_if #(
    parameter int LINE_W = skcim_pkg::MAX_LOG_SETS_DEF + skcim_pkg::WAY_W
) ();
    logic              valid;
    logic              ready;
    logic [LINE_W-1:0] line_way0;
    logic [LINE_W-1:0] line_way1;
    logic [LINE_W-1:0] line_way2;
    logic [LINE_W-1:0] line_way3;

    modport source (output valid, output line_way0, output line_way1,
                    output line_way2, output line_way3, input ready);
    modport sink   (input valid, input line_way0, input line_way1,
                    input line_way2, input line_way3, output ready);
endinterface

`default_nettype wire

>>> design/skcim_cfg_regs.sv
// Configuration registers: map mode, set field width and way count.
`default_nettype none

module skcim_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [skcim_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [skcim_pkg::CFG_W-1:0]        i_cfg_wdata,
    output skcim_pkg::t_cfg                         o_cfg
);

    skcim_pkg::t_cfg r_cfg;
    skcim_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                skcim_pkg::CFG_MAP_MODE: begin
                    n_cfg.map_mode = skcim_pkg::t_map_mode'(
                        i_cfg_wdata[skcim_pkg::MODE_W-1:0]);
                end
                skcim_pkg::CFG_LOG_SETS: begin
                    n_cfg.log_sets = i_cfg_wdata[skcim_pkg::LS_W-1:0];
                end
                skcim_pkg::CFG_WAY_COUNT: begin
                    n_cfg.way_count = i_cfg_wdata[skcim_pkg::WC_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_mode  <= skcim_pkg::RST_MAP_MODE;
            r_cfg.log_sets  <= skcim_pkg::RST_LOG_SETS;
            r_cfg.way_count <= skcim_pkg::RST_WAY_COUNT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> design/skcim_index_map.sv
// Skewing functions: block address to the four bank line indexes.
`default_nettype none

module skcim_index_map #(
    parameter  int MAX_LOG_SETS = skcim_pkg::MAX_LOG_SETS_DEF,
    localparam int ADDR_W       = 2 * MAX_LOG_SETS,
    localparam int LINE_W       = MAX_LOG_SETS + skcim_pkg::WAY_W
) (
    input  skcim_pkg::t_cfg         i_cfg,
    input  wire logic [ADDR_W-1:0]  i_block_addr,
    output logic [LINE_W-1:0]       o_line [skcim_pkg::NUM_WAYS]
);

    localparam int W    = MAX_LOG_SETS;
    localparam int LS_W = skcim_pkg::LS_W;

    function automatic logic f_top(input logic [W-1:0] x, input logic [LS_W-1:0] n);
        logic b;
        b = 1'b0;
        for (int i = 0; i < W; i++) begin
            if (i + 1 == int'(n)) b = x[i];
        end
        return b;
    endfunction

    function automatic logic [W-1:0] f_rotl(input logic [W-1:0] x,
                                            input logic [LS_W-1:0] n,
                                            input logic [W-1:0] mask);
        logic [W-1:0] y;
        y = x << 1;
        y[0] = f_top(x, n);
        return y & mask;
    endfunction

    function automatic logic [W-1:0] f_rev(input logic [W-1:0] x,
                                           input logic [LS_W-1:0] n);
        logic [W-1:0] y;
        y = '0;
        for (int i = 0; i < W; i++) begin
            for (int j = 0; j < W; j++) begin
                if (i + j + 1 == int'(n)) y[i] = y[i] | x[j];
            end
        end
        return y;
    endfunction

    function automatic logic [W-1:0] f_unshuf(input logic [W-1:0] x,
                                              input logic [LS_W-1:0] n);
        logic [W-1:0] y;
        int           half;
        y    = '0;
        half = int'(n >> 1);
        for (int m = 0; m < W; m++) begin
            if ((m & 1) == 1) begin
                y[(m - 1) / 2] = y[(m - 1) / 2] | x[m];
            end else begin
                for (int j = 0; j < W; j++) begin
                    if (j == m / 2 + half) y[j] = y[j] | x[m];
                end
            end
        end
        return y;
    endfunction

    function automatic logic [W-1:0] f_h(input logic [W-1:0] y,
                                         input logic [LS_W-1:0] n,
                                         input logic [W-1:0] mask);
        logic fb;
        fb = y[0] ^ f_top(y, n);
        return ((y << 1) | W'(fb)) & mask;
    endfunction

    function automatic logic [W-1:0] f_g(input logic [W-1:0] y,
                                         input logic [LS_W-1:0] n);
        logic [W:0]   ye;
        logic [W-1:0] g;
        logic         fb;
        ye = {1'b0, y};
        fb = ye[1] ^ ye[0];
        g  = y >> 1;
        for (int i = 0; i < W; i++) begin
            if (i + 1 == int'(n)) g[i] = g[i] | fb;
        end
        return g;
    endfunction

    logic [LS_W-1:0]   n;
    logic [W-1:0]      mask;
    logic [ADDR_W-1:0] addr_hi;
    logic [W-1:0]      a1;
    logic [W-1:0]      a2;
    logic [W-1:0]      rot;
    logic [W-1:0]      rev;
    logic [W-1:0]      h1;
    logic [W-1:0]      g1;
    logic [W-1:0]      h2;
    logic [W-1:0]      g2;
    logic [W-1:0]      set [skcim_pkg::NUM_WAYS];
    logic              way_ok;

    always_comb begin
        n = (i_cfg.log_sets > LS_W'(MAX_LOG_SETS)) ? LS_W'(MAX_LOG_SETS) : i_cfg.log_sets;
        for (int i = 0; i < W; i++) begin
            mask[i] = (i < int'(n));
        end
        addr_hi = i_block_addr >> n;
        a1      = i_block_addr[W-1:0] & mask;
        a2      = addr_hi[W-1:0] & mask;

        rot = '0;
        rev = '0;
        h1  = f_h(a1, n, mask);
        g1  = f_g(a1, n);
        h2  = f_h(a2, n, mask);
        g2  = f_g(a2, n);
        for (int k = 0; k < skcim_pkg::NUM_WAYS; k++) begin
            set[k] = '0;
        end

        case (i_cfg.map_mode)
            skcim_pkg::MAP_UNSHUF: begin
                rot = f_unshuf(a1, n);
                rev = f_rev(f_unshuf(a2, n), n);
                for (int k = 0; k < skcim_pkg::NUM_WAYS; k++) begin
                    set[k] = rev ^ rot;
                    rot    = f_rotl(rot, n, mask);
                end
            end
            skcim_pkg::MAP_HG: begin
                set[0] = h1 ^ g2 ^ a2;
                set[1] = h1 ^ g2 ^ a1;
                set[2] = g1 ^ h2 ^ a2;
                set[3] = g1 ^ h2 ^ a1;
            end
            skcim_pkg::MAP_ROT: begin
                rot = a1;
                for (int k = 0; k < skcim_pkg::NUM_WAYS; k++) begin
                    set[k] = rot ^ a2;
                    rot    = f_rotl(rot, n, mask);
                end
            end
            default: begin
                rot = '0;
            end
        endcase

        way_ok = 1'b0;
        for (int k = 0; k < skcim_pkg::NUM_WAYS; k++) begin
            way_ok = (i_cfg.map_mode != skcim_pkg::MAP_OFF) &&
                     ((i_cfg.map_mode != skcim_pkg::MAP_ROT) ||
                      (k < int'(i_cfg.way_count)));
            o_line[k] = way_ok ? (LINE_W'(set[k] & mask) | (LINE_W'(k) << n)) : '0;
        end
    end

endmodule

`default_nettype wire

>>> design/skewed_cache_index_map_core.sv
// Top level: input register, skewing logic, result register and config port.
//
//   channel   modport  payload                         transaction when
//   i_addr    sink     block_addr                      valid && ready
//   o_line    source   line_way0 .. line_way3          valid && ready
//   i_cfg_*   write    i_cfg_idx, i_cfg_wdata          i_cfg_we
//
// One address per cycle while o_line is ready; from accept to result valid an address
// passes the input register and the result register around the skew logic.
// Synchronous active-low reset clears both stage valids and loads the
// configuration defaults. A stalled result holds; the input stage keeps
// accepting while either stage has room.
`default_nettype none

module skewed_cache_index_map_core #(
    parameter int MAX_LOG_SETS = skcim_pkg::MAX_LOG_SETS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    skcim_addr_if.sink                              i_addr,
    skcim_line_if.source                            o_line,
    input  wire logic                               i_cfg_we,
    input  wire logic [skcim_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [skcim_pkg::CFG_W-1:0]        i_cfg_wdata
);

    localparam int ADDR_W = 2 * MAX_LOG_SETS;
    localparam int LINE_W = MAX_LOG_SETS + skcim_pkg::WAY_W;

    skcim_pkg::t_cfg   cfg;
    logic [LINE_W-1:0] line [skcim_pkg::NUM_WAYS];

    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s2_valid;
    logic [LINE_W-1:0] r_line [skcim_pkg::NUM_WAYS];
    logic              adv_s1;
    logic              adv_s2;

    skcim_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    skcim_index_map #(
        .MAX_LOG_SETS (MAX_LOG_SETS)
    ) u_index_map (
        .i_cfg        (cfg),
        .i_block_addr (r_s1_addr),
        .o_line       (line)
    );

    assign adv_s2       = !r_s2_valid || o_line.ready;
    assign adv_s1       = !r_s1_valid || adv_s2;
    assign i_addr.ready = adv_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (adv_s1) begin
                r_s1_valid <= i_addr.valid;
            end
            if (adv_s2) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_s1 && i_addr.valid) begin
            r_s1_addr <= i_addr.block_addr;
        end
        if (adv_s2 && r_s1_valid) begin
            r_line <= line;
        end
    end

    assign o_line.valid     = r_s2_valid;
    assign o_line.line_way0 = r_line[0];
    assign o_line.line_way1 = r_line[1];
    assign o_line.line_way2 = r_line[2];
    assign o_line.line_way3 = r_line[3];

endmodule

`default_nettype wire
